/* hdl/msf_pkg.sv */
// Shared types and constants of the memory value search filter.
`timescale 1ns / 1ps

package msf_pkg;

    // Field widths
    localparam int ADDR_W    = 18;
    localparam int WADDR_W   = ADDR_W - 2;
    localparam int COUNT_W   = 19;
    localparam int DATA_W    = 32;
    localparam int LANES     = 4;

    // Running count saturates at all ones
    localparam logic [COUNT_W-1:0] TALLY_MAX = '1;

    // Item modes (codes above MODE_QUERY act as a query)
    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_CMP_SNAP = 3'd1;
    localparam logic [2:0] MODE_CMP_VAL  = 3'd2;
    localparam logic [2:0] MODE_REFRESH  = 3'd3;
    localparam logic [2:0] MODE_QUERY    = 3'd4;

    // Compare codes
    localparam logic [2:0] OP_EQ = 3'd0;
    localparam logic [2:0] OP_NE = 3'd1;
    localparam logic [2:0] OP_LT = 3'd2;
    localparam logic [2:0] OP_LE = 3'd3;
    localparam logic [2:0] OP_GT = 3'd4;
    localparam logic [2:0] OP_GE = 3'd5;

    // Element size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_COMPARE_OP     = 2'd0;
    localparam logic [1:0] REG_ELEMENT_SIZE   = 2'd1;
    localparam logic [1:0] REG_SIGNED_COMPARE = 2'd2;
    localparam logic [1:0] REG_SEARCH_VALUE   = 2'd3;

    typedef struct packed {
        logic [2:0]        compare_op;
        logic [1:0]        element_size;
        logic              signed_compare;
        logic [DATA_W-1:0] search_value;
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] addr;
        logic [LANES-1:0]   cand;
        logic [DATA_W-1:0]  snap;
    } store_wr_t;

    typedef struct packed {
        logic [LANES-1:0]  cand;
        logic [DATA_W-1:0] snap;
        logic              hit;
    } eval_out_t;

endpackage

/* hdl/msf_in_if.sv */
// Input item channel of the search filter.
`timescale 1ns / 1ps

interface msf_in_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   mode;
    logic [msf_pkg::ADDR_W-1:0]   byte_address;
    logic [msf_pkg::DATA_W-1:0]   current_value;
    logic                         pass_last;

    modport source (output valid, output mode, output byte_address,
                    output current_value, output pass_last, input ready);
    modport sink   (input valid, input mode, input byte_address,
                    input current_value, input pass_last, output ready);
endinterface

/* hdl/msf_out_if.sv */
// Result channel of the search filter.
`timescale 1ns / 1ps

interface msf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         still_candidate;
    logic [msf_pkg::COUNT_W-1:0]  running_count;

    modport source (output valid, output still_candidate, output running_count,
                    input ready);
    modport sink   (input valid, input still_candidate, input running_count,
                    output ready);
endinterface

/* hdl/memory_value_search_filter_unit.sv */
// Top level of the memory value search filter.
`timescale 1ns / 1ps
// An accepted item passes the stage 1 registers, then the result register.
// Throughput: one item per cycle while no result stalls and no clearing pass runs; one
// read-modify-write stage on the word memories, with write-to-read bypass when
// consecutive items hit one word. Reset: control and configuration clear at once;
// then a clearing pass zeroes min(MEM_BYTES, 262144)/4 candidate words, rounded up,
// with no item accepted. Snapshot bytes are not cleared and are undefined until written.

module memory_value_search_filter_unit #(
    parameter int MEM_BYTES = 262144
) (
    input  logic                        clk,
    input  logic                        rst_n,
    msf_in_if.sink                      item,
    msf_out_if.source                   result,
    input  logic                        wr_en,
    input  logic [1:0]                  wr_index,
    input  logic [msf_pkg::DATA_W-1:0]  wr_data
);

    localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);

    msf_pkg::cfg_t      cfg_reg;
    msf_pkg::store_rd_t rd;
    msf_pkg::store_wr_t wr;
    msf_pkg::eval_out_t ev;

    logic                        s1_valid_reg;
    logic [2:0]                  s1_mode_reg;
    logic [msf_pkg::ADDR_W-1:0]  s1_addr_reg;
    logic [msf_pkg::DATA_W-1:0]  s1_cur_reg;
    logic                        s1_last_reg;

    logic                        res_valid_reg;
    logic                        res_cand_reg;
    logic [msf_pkg::COUNT_W-1:0] res_count_reg;
    logic [msf_pkg::COUNT_W-1:0] tally_reg;
    logic [msf_pkg::COUNT_W-1:0] tally_next;

    logic [msf_pkg::ADDR_W-1:0]  addr_aligned;
    logic [msf_pkg::LANES-1:0]   rd_cand;
    logic [msf_pkg::DATA_W-1:0]  rd_snap;
    logic [msf_pkg::LANES-1:0]   in_range;
    logic                        busy;
    logic                        s1_fire;
    logic                        accept;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                msf_pkg::REG_COMPARE_OP:     cfg_reg.compare_op     <= wr_data[2:0];
                msf_pkg::REG_ELEMENT_SIZE:   cfg_reg.element_size   <= wr_data[1:0];
                msf_pkg::REG_SIGNED_COMPARE: cfg_reg.signed_compare <= wr_data[0];
                msf_pkg::REG_SEARCH_VALUE:   cfg_reg.search_value   <= wr_data;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Handshake control
    assign s1_fire    = s1_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !busy && (!s1_valid_reg || s1_fire);
    assign accept     = item.valid && item.ready;

    // Align element start to its width
    always_comb
    begin
        case (cfg_reg.element_size)
            msf_pkg::SIZE_HALF: addr_aligned = {item.byte_address[17:1], 1'b0};
            msf_pkg::SIZE_WORD: addr_aligned = {item.byte_address[17:2], 2'b00};
            default:            addr_aligned = item.byte_address;
        endcase
    end

    // Read issued on acceptance
    assign rd.en   = accept;
    assign rd.addr = addr_aligned[msf_pkg::ADDR_W-1:2];

    // Stage 1 item registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= item.mode;
            s1_addr_reg <= addr_aligned;
            s1_cur_reg  <= item.current_value;
            s1_last_reg <= item.pass_last;
        end
    end

    // Bytes of the word that lie inside memory
    always_comb
    begin
        for (int k = 0; k < msf_pkg::LANES; k++)
        begin
            in_range[k] = (32'({s1_addr_reg[msf_pkg::ADDR_W-1:2], 2'(k)}) < MEM_LIMIT);
        end
    end

    msf_store #(
        .MEM_BYTES (MEM_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .wr      (wr),
        .rd_cand (rd_cand),
        .rd_snap (rd_snap),
        .busy    (busy)
    );

    msf_eval u_eval (
        .cfg           (cfg_reg),
        .mode          (s1_mode_reg),
        .lane          (s1_addr_reg[1:0]),
        .current_value (s1_cur_reg),
        .old_cand      (rd_cand),
        .old_snap      (rd_snap),
        .in_range      (in_range),
        .res           (ev)
    );

    // Write back the updated word when it exists in memory
    assign wr.en   = s1_fire && in_range[0];
    assign wr.addr = s1_addr_reg[msf_pkg::ADDR_W-1:2];
    assign wr.cand = ev.cand;
    assign wr.snap = ev.snap;

    // Saturating pass tally
    assign tally_next = (ev.hit && (tally_reg != msf_pkg::TALLY_MAX))
                      ? tally_reg + 1'b1 : tally_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
        end
        else if (s1_fire)
        begin
            tally_reg <= s1_last_reg ? '0 : tally_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_cand_reg  <= ev.hit;
            res_count_reg <= tally_next;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.still_candidate = res_cand_reg;
    assign result.running_count   = res_count_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !item.ready)
        else $error("item accepted during clearing pass");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stalled stage lost its item");

    a_fire_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> res_valid_reg)
        else $error("finished item produced no result");

    a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (tally_reg == '0))
        else $error("tally not cleared after last item of pass");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_cand_reg) |-> (res_count_reg != '0))
        else $error("candidate reported with zero count");

endmodule

/* hdl/msf_store.sv */
// Word-organized candidate and snapshot memories with clear pass and bypass.
`timescale 1ns / 1ps

module msf_store #(
    parameter int MEM_BYTES = 262144
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  msf_pkg::store_rd_t          rd,
    input  msf_pkg::store_wr_t          wr,
    output logic [msf_pkg::LANES-1:0]   rd_cand,
    output logic [msf_pkg::DATA_W-1:0]  rd_snap,
    output logic                        busy
);

    // Only the first 2^ADDR_W bytes are reachable by an address
    localparam int REACH_BYTES = 2 ** msf_pkg::ADDR_W;
    localparam int STORE_BYTES = (MEM_BYTES < REACH_BYTES) ? MEM_BYTES : REACH_BYTES;
    localparam int WORDS       = (STORE_BYTES + msf_pkg::LANES - 1) / msf_pkg::LANES;
    localparam int WA_W        = $clog2(WORDS);
    localparam int CLR_W       = $clog2(WORDS + 1);

    logic [msf_pkg::LANES-1:0]  cand_mem [WORDS];
    logic [msf_pkg::DATA_W-1:0] snap_mem [WORDS];

    logic [CLR_W-1:0]           clr_cnt_reg;
    logic [msf_pkg::LANES-1:0]  rd_cand_reg;
    logic [msf_pkg::DATA_W-1:0] rd_snap_reg;
    logic                       bypass;

    assign busy   = (clr_cnt_reg != CLR_W'(WORDS));
    assign bypass = wr.en && (wr.addr == rd.addr);

    // Clearing pass over the candidate words after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (busy)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Candidate memory: clear sweep, write port, registered read with bypass
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            cand_mem[clr_cnt_reg[WA_W-1:0]] <= '0;
        end
        else if (wr.en)
        begin
            cand_mem[wr.addr[WA_W-1:0]] <= wr.cand;
        end
        if (rd.en)
        begin
            rd_cand_reg <= bypass ? wr.cand : cand_mem[rd.addr[WA_W-1:0]];
        end
    end

    // Snapshot memory: no reset, registered read with bypass
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            snap_mem[wr.addr[WA_W-1:0]] <= wr.snap;
        end
        if (rd.en)
        begin
            rd_snap_reg <= bypass ? wr.snap : snap_mem[rd.addr[WA_W-1:0]];
        end
    end

    assign rd_cand = rd_cand_reg;
    assign rd_snap = rd_snap_reg;

    // No read or write reaches the store during the clearing pass
    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr.en && !rd.en)
        else $error("store accessed during clearing pass");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("clearing pass restarted without reset");

    a_bypass_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rd.en && bypass) |=> (rd_cand_reg == $past(wr.cand)))
        else $error("bypass did not return written candidate word");

endmodule

/* hdl/msf_eval.sv */
// Per-element update: snapshot merge, compare and candidate bit rewrite.
`timescale 1ns / 1ps

module msf_eval (
    input  msf_pkg::cfg_t               cfg,
    input  logic [2:0]                  mode,
    input  logic [1:0]                  lane,
    input  logic [msf_pkg::DATA_W-1:0]  current_value,
    input  logic [msf_pkg::LANES-1:0]   old_cand,
    input  logic [msf_pkg::DATA_W-1:0]  old_snap,
    input  logic [msf_pkg::LANES-1:0]   in_range,
    output msf_pkg::eval_out_t          res
);

    // Zero- or sign-extend an element to 32 bits
    function automatic logic [msf_pkg::DATA_W-1:0] widen(
        input logic [msf_pkg::DATA_W-1:0] v,
        input logic [1:0]                 size,
        input logic                       sgn
    );
        logic [msf_pkg::DATA_W-1:0] w;
        case (size)
            msf_pkg::SIZE_HALF: w = {{16{sgn & v[15]}}, v[15:0]};
            msf_pkg::SIZE_WORD: w = v;
            default:            w = {{24{sgn & v[7]}}, v[7:0]};
        endcase
        return w;
    endfunction

    logic [msf_pkg::LANES-1:0]  elem_mask;
    logic [msf_pkg::DATA_W-1:0] byte_mask;
    logic [msf_pkg::DATA_W-1:0] range_bits;
    logic [msf_pkg::DATA_W-1:0] repl;
    logic [msf_pkg::DATA_W-1:0] snap_in;
    logic [msf_pkg::DATA_W-1:0] raw;
    logic [msf_pkg::DATA_W-1:0] op_a;
    logic [msf_pkg::DATA_W-1:0] op_b;
    logic                       cmp_pass;
    logic                       do_cmp;
    logic [msf_pkg::LANES-1:0]  cand_in;

    // Lane masks of the element and of stored bytes
    always_comb
    begin
        case (cfg.element_size)
            msf_pkg::SIZE_HALF:
            begin
                elem_mask = 4'b0011 << lane;
                repl      = {2{current_value[15:0]}};
            end
            msf_pkg::SIZE_WORD:
            begin
                elem_mask = 4'b1111;
                repl      = current_value;
            end
            default:
            begin
                elem_mask = 4'b0001 << lane;
                repl      = {4{current_value[7:0]}};
            end
        endcase
        for (int k = 0; k < msf_pkg::LANES; k++)
        begin
            byte_mask[8*k +: 8]  = {8{elem_mask[k]}};
            range_bits[8*k +: 8] = {8{in_range[k]}};
        end
    end

    // Bytes outside memory read as zero
    assign snap_in = old_snap & range_bits;
    assign cand_in = old_cand & in_range;
    assign raw     = snap_in >> {lane, 3'b000};

    // Operands, sign bit flipped for signed order
    always_comb
    begin
        op_a = widen(current_value, cfg.element_size, cfg.signed_compare);
        op_b = (mode == msf_pkg::MODE_CMP_SNAP)
             ? widen(raw, cfg.element_size, cfg.signed_compare)
             : cfg.search_value;
        if (cfg.signed_compare)
        begin
            op_a[31] = ~op_a[31];
            op_b[31] = ~op_b[31];
        end
        case (cfg.compare_op)
            msf_pkg::OP_EQ: cmp_pass = (op_a == op_b);
            msf_pkg::OP_NE: cmp_pass = (op_a != op_b);
            msf_pkg::OP_LT: cmp_pass = (op_a <  op_b);
            msf_pkg::OP_LE: cmp_pass = (op_a <= op_b);
            msf_pkg::OP_GT: cmp_pass = (op_a >  op_b);
            default:        cmp_pass = (op_a >= op_b);
        endcase
    end

    assign do_cmp = ((mode == msf_pkg::MODE_CMP_SNAP) || (mode == msf_pkg::MODE_CMP_VAL))
                 && (cfg.compare_op <= msf_pkg::OP_GE)
                 && cand_in[lane];

    // Next word contents
    always_comb
    begin
        res.cand = cand_in;
        res.snap = snap_in;
        case (mode)
            msf_pkg::MODE_START:
            begin
                res.snap = (snap_in & ~byte_mask) | (repl & byte_mask);
                res.cand = cand_in | (elem_mask & in_range);
            end
            msf_pkg::MODE_REFRESH:
            begin
                res.snap = (snap_in & ~byte_mask) | (repl & byte_mask);
            end
            msf_pkg::MODE_CMP_SNAP, msf_pkg::MODE_CMP_VAL:
            begin
                if (do_cmp && !cmp_pass)
                begin
                    res.cand = cand_in & ~elem_mask;
                end
            end
            default:
            begin
                res.cand = cand_in;
            end
        endcase
        res.hit = res.cand[lane];
    end

endmodule
